// ----- sv/hte_pkg.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor package
// Shared request/response/plan types, queue sizing and match-pattern tables.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [7:0] CH_LT    = "<";
   localparam logic [7:0] CH_GT    = ">";
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_C     = "c";
   localparam logic [7:0] CH_T     = "t";

   localparam logic [2:0] OPEN_SCRIPT_LEN  = 3'd7;
   localparam logic [2:0] OPEN_STYLE_LEN   = 3'd6;
   localparam logic [2:0] OPEN_BRANCH_IDX  = 3'd2;
   localparam logic [3:0] CLOSE_SCRIPT_LEN = 4'd9;
   localparam logic [3:0] CLOSE_STYLE_LEN  = 4'd8;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       doc_last;
   } req_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_valid;
      logic       doc_end;
   } rsp_type;

   // up to two responses produced by one request
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } plan_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "A" && c <= "Z") begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [7:0] open_char(input logic style, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (style) begin
         unique case (idx)
            3'd0: c = "<";
            3'd1: c = "s";
            3'd2: c = "t";
            3'd3: c = "y";
            3'd4: c = "l";
            3'd5: c = "e";
            default: c = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0: c = "<";
            3'd1: c = "s";
            3'd2: c = "c";
            3'd3: c = "r";
            3'd4: c = "i";
            3'd5: c = "p";
            3'd6: c = "t";
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   function automatic logic [7:0] close_char(input logic style, input logic [3:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (style) begin
         unique case (idx)
            4'd0: c = "<";
            4'd1: c = "/";
            4'd2: c = "s";
            4'd3: c = "t";
            4'd4: c = "y";
            4'd5: c = "l";
            4'd6: c = "e";
            4'd7: c = ">";
            default: c = 8'h00;
         endcase
      end else begin
         unique case (idx)
            4'd0: c = "<";
            4'd1: c = "/";
            4'd2: c = "s";
            4'd3: c = "c";
            4'd4: c = "r";
            4'd5: c = "i";
            4'd6: c = "p";
            4'd7: c = "t";
            4'd8: c = ">";
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

endpackage

// ----- sv/hte_front.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor front end
// Takes one byte per cycle while the queue is not full, tracks tag/script/style and whitespace state,
// and turns each request into a plan of up to two responses.
// ----------------------------------------------------------------------------
module hte_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hte_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              push,
   output hte_pkg::plan_type plan
);

   logic [2:0] oml_ff, oml_in;
   logic       ois_ff, ois_in;
   logic       skip_ff, skip_in;
   logic [3:0] cml_ff, cml_in;
   logic       itag_ff, itag_in;
   logic       spend_ff, spend_in;
   logic       seen_ff, seen_in;

   logic       accept;
   logic [7:0] b, l;
   logic [2:0] no, oplen;
   logic [3:0] nc, cplen;
   logic       fo, fk, ft, fp, fn, fresh, ok;
   logic [1:0] nres;
   logic [7:0] em0, em1;
   logic       last;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   always_comb begin
      b     = req_data.in_byte;
      last  = req_data.doc_last;
      l     = hte_pkg::fold_lower(b);
      no    = oml_ff;
      fo    = ois_ff;
      fk    = skip_ff;
      nc    = cml_ff;
      ft    = itag_ff;
      fp    = spend_ff;
      fn    = seen_ff;
      fresh = 1'b1;
      ok    = 1'b0;
      nres  = 2'd0;
      em0   = 8'h00;
      em1   = 8'h00;
      oplen = hte_pkg::OPEN_SCRIPT_LEN;
      cplen = ois_ff ? hte_pkg::CLOSE_STYLE_LEN : hte_pkg::CLOSE_SCRIPT_LEN;

      if (skip_ff) begin
         if (cml_ff < cplen && l == hte_pkg::close_char(ois_ff, cml_ff)) begin
            nc = cml_ff + 4'd1;
            if (nc >= cplen) begin
               fk = 1'b0;
               nc = 4'd0;
               fo = 1'b0;
            end
         end else begin
            nc = (b == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
         end
      end else begin
         if (oml_ff != 3'd0) begin
            if (oml_ff == hte_pkg::OPEN_BRANCH_IDX) begin
               ok = (l == hte_pkg::CH_C) || (l == hte_pkg::CH_T);
               if (ok) begin
                  fo = (l == hte_pkg::CH_T);
               end
            end else begin
               oplen = ois_ff ? hte_pkg::OPEN_STYLE_LEN : hte_pkg::OPEN_SCRIPT_LEN;
               ok = (oml_ff < oplen) && (l == hte_pkg::open_char(ois_ff, oml_ff));
            end
            if (ok) begin
               fresh = 1'b0;
               no    = oml_ff + 3'd1;
               oplen = fo ? hte_pkg::OPEN_STYLE_LEN : hte_pkg::OPEN_SCRIPT_LEN;
               if (no >= oplen) begin
                  no = 3'd0;
                  fk = 1'b1;
                  nc = 4'd0;
               end
            end else begin
               // held '<' released: becomes a tag start, and a pending space if text was seen
               no = 3'd0;
               fo = 1'b0;
               ft = 1'b1;
               if (fn) begin
                  fp = 1'b1;
               end
            end
         end
         if (fresh) begin
            if (b == hte_pkg::CH_LT) begin
               no = 3'd1;
               fo = 1'b0;
            end else if (b == hte_pkg::CH_GT) begin
               ft = 1'b0;
            end else if (!ft) begin
               if (hte_pkg::is_ws(b)) begin
                  if (fn) begin
                     fp = 1'b1;
                  end
               end else begin
                  if (fp) begin
                     em0  = hte_pkg::CH_SPACE;
                     em1  = b;
                     nres = 2'd2;
                  end else begin
                     em0  = b;
                     nres = 2'd1;
                  end
                  fp = 1'b0;
                  fn = 1'b1;
               end
            end
         end
      end

      plan.two               = (nres == 2'd2);
      plan.first.text_byte   = em0;
      plan.first.text_valid  = (nres != 2'd0);
      plan.first.doc_end     = last && (nres != 2'd2);
      plan.second.text_byte  = em1;
      plan.second.text_valid = 1'b1;
      plan.second.doc_end    = last;
      push = accept && ((nres != 2'd0) || last);

      oml_in   = oml_ff;
      ois_in   = ois_ff;
      skip_in  = skip_ff;
      cml_in   = cml_ff;
      itag_in  = itag_ff;
      spend_in = spend_ff;
      seen_in  = seen_ff;
      if (accept) begin
         if (last) begin
            oml_in   = 3'd0;
            ois_in   = 1'b0;
            skip_in  = 1'b0;
            cml_in   = 4'd0;
            itag_in  = 1'b0;
            spend_in = 1'b0;
            seen_in  = 1'b0;
         end else begin
            oml_in   = no;
            ois_in   = fo;
            skip_in  = fk;
            cml_in   = nc;
            itag_in  = ft;
            spend_in = fp;
            seen_in  = fn;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oml_ff   <= 3'd0;
         ois_ff   <= 1'b0;
         skip_ff  <= 1'b0;
         cml_ff   <= 4'd0;
         itag_ff  <= 1'b0;
         spend_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         oml_ff   <= oml_in;
         ois_ff   <= ois_in;
         skip_ff  <= skip_in;
         cml_ff   <= cml_in;
         itag_ff  <= itag_in;
         spend_ff <= spend_in;
         seen_ff  <= seen_in;
      end
   end

   a_skip_no_open: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (oml_ff == 3'd0))
      else $error("open prefix held while skipping a block");

   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      !skip_ff |-> (cml_ff == 4'd0))
      else $error("close match count live outside a skipped block");

   a_space_after_text: assert property (@(posedge clock) disable iff (reset)
      spend_ff |-> seen_ff)
      else $error("pending space with no text seen");

   a_two_needs_space: assert property (@(posedge clock) disable iff (reset)
      (push && plan.two) |-> (plan.first.text_byte == hte_pkg::CH_SPACE))
      else $error("double response without leading space");

endmodule

// ----- sv/hte_queue.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor plan queue
// Short FIFO of response plans decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module hte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hte_pkg::plan_type entry_in,
   output logic              full,
   output logic              head_valid,
   output hte_pkg::plan_type head,
   input  logic              pop
);

   hte_pkg::plan_type         mem_ff [hte_pkg::QDEPTH];
   logic [hte_pkg::QAW-1:0]   wr_ff, wr_in;
   logic [hte_pkg::QAW-1:0]   rd_ff, rd_in;
   logic [hte_pkg::QAW:0]     count_ff, count_in;
   logic                      do_pop;

   assign full       = (count_ff == (hte_pkg::QAW+1)'(hte_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (hte_pkg::QAW+1)'(hte_pkg::QDEPTH))
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ff == rd_ff))
      else $error("empty queue with pointers apart");

endmodule

// ----- sv/hte_back.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor back end
// Splits each plan into single responses and holds them in the output register.
// ----------------------------------------------------------------------------
module hte_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  hte_pkg::plan_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hte_pkg::rsp_type  rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   hte_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             second_ff, second_in;
   logic             load;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         rsp_data_in  = second_ff ? head.second : head.first;
         if (head_valid) begin
            pop       = second_ff || !head.two;
            second_in = !second_ff && head.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (head_valid && head.two))
      else $error("second half pending without a double plan");

   a_second_no_pop_first: assert property (@(posedge clock) disable iff (reset)
      (load && head_valid && head.two && !second_ff) |-> !pop)
      else $error("double plan popped after its first half");

   a_end_marker_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.text_valid) |-> rsp_data_ff.doc_end)
      else $error("empty response that is not a document end");

endmodule

// ----- sv/html_text_extractor_core.sv -----
// ----------------------------------------------------------------------------
// HTML text extractor core
// A request's plan is registered in the queue, then loaded into the output register.
// Throughput: one request per cycle while the queue is not full; a request giving two
// responses holds the response port for both, with a four-plan queue absorbing the burst.
// Reset: synchronous, clears all match/whitespace state, the queue pointers and the output valid.
// ----------------------------------------------------------------------------
module html_text_extractor_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hte_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hte_pkg::rsp_type rsp_data
);

   logic              q_full;
   logic              push;
   hte_pkg::plan_type plan;
   logic              head_valid;
   hte_pkg::plan_type head;
   logic              pop;

   hte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .plan      (plan)
   );

   hte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .entry_in   (plan),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   hte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTML text extractor testbench
// Feeds byte streams of HTML documents into the core: a short directed table,
// then random documents built from text, whitespace, tags, script and style
// blocks, broken openers and raw noise. Each accepted request is run through
// a local text predictor and the responses are checked in order against it.
// Sender bursts and receiver stalls at random, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RANDOM_REQS = 1450;
   localparam int LIMIT       = 200000;

   typedef struct packed {
      logic [7:0]       in_byte;
      logic             doc_last;
      logic             typed;
      hte_pkg::rsp_type want;
   } dir_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hte_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hte_pkg::rsp_type rsp_data;

   // predictor state
   logic [2:0] om_len   = '0;
   logic       sty      = 1'b0;
   logic       skipping = 1'b0;
   logic [3:0] cm_len   = '0;
   logic       in_tag   = 1'b0;
   logic       sp_pend  = 1'b0;
   logic       seen     = 1'b0;

   hte_pkg::rsp_type step_out [$];
   hte_pkg::rsp_type text_due [$];
   logic [7:0]       doc_q [$];
   int               reqs_sent  = 0;
   int               burst_left = 0;
   int               errors     = 0;
   int               cycles     = 0;

   dir_row_type dir_rows [23] = '{
      '{8'h00,             1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{8'hFF,             1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{8'h09,             1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{hte_pkg::CH_LT,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{hte_pkg::CH_GT,    1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{"a",               1'b0, 1'b0, '0},
      '{8'h0D,             1'b0, 1'b0, '0},
      '{hte_pkg::CH_LT,    1'b0, 1'b0, '0},
      '{"x",               1'b0, 1'b0, '0},
      '{hte_pkg::CH_GT,    1'b0, 1'b0, '0},
      '{"B",               1'b0, 1'b0, '0},
      '{hte_pkg::CH_SPACE, 1'b1, 1'b0, '0},
      // unclosed style block
      '{hte_pkg::CH_LT,    1'b0, 1'b0, '0},
      '{"S",               1'b0, 1'b0, '0},
      '{"T",               1'b0, 1'b0, '0},
      '{"y",               1'b0, 1'b0, '0},
      '{"L",               1'b0, 1'b0, '0},
      '{"e",               1'b0, 1'b0, '0},
      '{"z",               1'b1, 1'b0, '0},
      // held opener prefix at the end
      '{"x",               1'b0, 1'b0, '0},
      '{hte_pkg::CH_LT,    1'b0, 1'b0, '0},
      '{"s",               1'b0, 1'b0, '0},
      '{"c",               1'b1, 1'b0, '0}
   };

   html_text_extractor_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [7:0] tag_char(input logic closing, input logic style,
                                           input int idx);
      logic [71:0] pat;
      if (closing) begin
         pat = style ? {"</style>", 8'h00} : "</script>";
      end else begin
         pat = style ? {"<style", 24'h0} : {"<script", 16'h0};
      end
      return pat[71 - 8 * idx -: 8];
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   task automatic clean_char(input logic [7:0] c);
      if (c == hte_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
         if (seen) begin
            sp_pend = 1'b1;
         end
      end else begin
         if (sp_pend) begin
            step_out.insert(step_out.size(),
                            hte_pkg::rsp_type'{hte_pkg::CH_SPACE, 1'b1, 1'b0});
         end
         step_out.insert(step_out.size(), hte_pkg::rsp_type'{c, 1'b1, 1'b0});
         sp_pend = 1'b0;
         seen    = 1'b1;
      end
   endtask

   task automatic strip_char(input logic [7:0] c);
      if (c == hte_pkg::CH_LT) begin
         in_tag = 1'b1;
         clean_char(hte_pkg::CH_SPACE);
      end else if (c == hte_pkg::CH_GT) begin
         in_tag = 1'b0;
      end else if (!in_tag) begin
         clean_char(c);
      end
   endtask

   task automatic predict_text(input hte_pkg::req_type r);
      logic [7:0] b;
      logic [7:0] l;
      logic [3:0] plen;
      logic       ok;
      logic       fresh;
      b = r.in_byte;
      l = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      step_out.delete();
      if (skipping) begin
         plen = sty ? 4'd8 : 4'd9;
         if (cm_len < plen && l == tag_char(1'b1, sty, int'(cm_len))) begin
            cm_len = cm_len + 4'd1;
            if (cm_len >= plen) begin
               skipping = 1'b0;
               cm_len   = '0;
               sty      = 1'b0;
            end
         end else begin
            cm_len = (b == hte_pkg::CH_LT) ? 4'd1 : 4'd0;
         end
      end else begin
         fresh = 1'b1;
         if (om_len != 0) begin
            if (om_len == 3'd2) begin
               ok = (l == "c" || l == "t");
               if (ok) begin
                  sty = (l == "t");
               end
            end else begin
               plen = sty ? 4'd6 : 4'd7;
               ok   = ({1'b0, om_len} < plen) && l == tag_char(1'b0, sty, int'(om_len));
            end
            if (ok) begin
               fresh  = 1'b0;
               om_len = om_len + 3'd1;
               if (om_len >= (sty ? 3'd6 : 3'd7)) begin
                  om_len   = '0;
                  skipping = 1'b1;
                  cm_len   = '0;
               end
            end else begin
               om_len = '0;
               sty    = 1'b0;
               strip_char(hte_pkg::CH_LT);
            end
         end
         if (fresh) begin
            if (b == hte_pkg::CH_LT) begin
               om_len = 3'd1;
               sty    = 1'b0;
            end else begin
               strip_char(b);
            end
         end
      end
      if (r.doc_last) begin
         if (step_out.size() == 0) begin
            step_out.insert(0, hte_pkg::rsp_type'{8'h00, 1'b0, 1'b1});
         end else begin
            step_out[step_out.size() - 1].doc_end = 1'b1;
         end
         om_len   = '0;
         sty      = 1'b0;
         skipping = 1'b0;
         cm_len   = '0;
         in_tag   = 1'b0;
         sp_pend  = 1'b0;
         seen     = 1'b0;
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_req(input logic [7:0] b, input logic last, input logic typed,
                           input hte_pkg::rsp_type want);
      int               gap;
      hte_pkg::req_type cur;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      cur.in_byte  = b;
      cur.doc_last = last;
      req_valid <= 1'b1;
      req_data  <= cur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_text(cur);
      if (typed) begin
         text_due.insert(text_due.size(), want);
      end else begin
         foreach (step_out[i]) text_due.insert(text_due.size(), step_out[i]);
      end
      reqs_sent++;
      @(negedge clock);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         doc_q.insert(doc_q.size(), flip_case(s[i]));
      end
   endtask

   task automatic add_word();
      int sel;
      repeat ($urandom_range(1, 8)) begin
         sel = $urandom_range(0, 5);
         case (sel)
            0, 1:    doc_q.insert(doc_q.size(), flip_case(8'($urandom_range("a", "z"))));
            2:       doc_q.insert(doc_q.size(), 8'($urandom_range("0", "9")));
            3:       doc_q.insert(doc_q.size(), 8'($urandom_range(128, 255)));
            4:       doc_q.insert(doc_q.size(), 8'($urandom_range(0, 8)));
            default: doc_q.insert(doc_q.size(), 8'($urandom_range(33, 59)));
         endcase
      end
   endtask

   task automatic add_ws();
      int sel;
      repeat ($urandom_range(1, 4)) begin
         sel = $urandom_range(9, 14);
         doc_q.insert(doc_q.size(), sel == 14 ? hte_pkg::CH_SPACE : 8'(sel));
      end
   endtask

   task automatic build_doc();
      logic  style;
      string open_kw;
      string close_kw;
      string cross_kw;
      int    cut;
      doc_q.delete();
      repeat ($urandom_range(1, 10)) begin
         style = 1'($urandom_range(0, 1));
         if (style) begin
            open_kw  = "<style";
            close_kw = "</style>";
            cross_kw = "</script>";
         end else begin
            open_kw  = "<script";
            close_kw = "</script>";
            cross_kw = "</style>";
         end
         case ($urandom_range(0, 9))
            0, 1, 9: add_word();
            2: add_ws();
            3: begin
               case ($urandom_range(0, 7))
                  0: add_text("<b");
                  1: add_text("<div class=x");
                  2: add_text("</p");
                  3: add_text("<s");
                  4: add_text("<scri");
                  5: add_text("<styl");
                  6: add_text("<sty le");
                  default: add_text("<br/");
               endcase
               if ($urandom_range(0, 3) == 0) add_word();
               add_text(">");
            end
            4, 5: begin
               add_text(open_kw);
               if ($urandom_range(0, 1) == 1) add_text(" type=\"t\"");
               add_text(">");
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(0, 4))
                     0: add_word();
                     1: add_ws();
                     2: add_text("<");
                     3: add_text(close_kw.substr(0, $urandom_range(0, close_kw.len() - 2)));
                     default: add_text(cross_kw);
                  endcase
               end
               if ($urandom_range(0, 7) != 0) begin
                  add_text(close_kw);
               end
            end
            6: begin
               add_text(open_kw.substr(0, $urandom_range(1, open_kw.len() - 2)));
               add_word();
               if ($urandom_range(0, 1) == 1) add_text(">");
            end
            7: begin
               if ($urandom_range(0, 1) == 1) begin
                  add_text(">");
               end else begin
                  add_text(">>");
               end
            end
            default: begin
               repeat ($urandom_range(1, 3)) doc_q.insert(doc_q.size(),
                                                          8'($urandom_range(0, 255)));
            end
         endcase
      end
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, doc_q.size());
         while (doc_q.size() > cut) doc_q.delete(doc_q.size() - 1);
      end
   endtask

   initial begin : stimulus
      int total;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].in_byte, dir_rows[i].doc_last, dir_rows[i].typed,
                  dir_rows[i].want);
      end
      total = reqs_sent + RANDOM_REQS;
      while (reqs_sent < total) begin
         build_doc();
         foreach (doc_q[i]) begin
            send_req(doc_q[i], i == doc_q.size() - 1, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (text_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : rsp_pacer
      int   n;
      logic held_long;
      held_long = 1'b0;
      @(negedge clock);
      forever begin
         if (!held_long && reqs_sent > 700) begin
            held_long = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end
         n = $urandom_range(1, 30);
         case ($urandom_range(0, 3))
            0: repeat (n) begin
               rsp_stall <= 1'b0;
               @(negedge clock);
            end
            1: repeat ($urandom_range(1, 8)) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
            default: repeat (n) begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               @(negedge clock);
            end
         endcase
      end
   end

   always @(posedge clock) begin : rsp_check
      hte_pkg::rsp_type due;
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (text_due.size() == 0) begin
            $display("%0t: expected no response, got %h", $time, rsp_data);
            errors++;
         end else begin
            due = text_due.pop_front();
            if (rsp_data.text_byte !== due.text_byte) begin
               $display("%0t: text_byte expected %h, got %h", $time, due.text_byte,
                        rsp_data.text_byte);
               errors++;
            end
            if (rsp_data.text_valid !== due.text_valid) begin
               $display("%0t: text_valid expected %b, got %b", $time, due.text_valid,
                        rsp_data.text_valid);
               errors++;
            end
            if (rsp_data.doc_end !== due.doc_end) begin
               $display("%0t: doc_end expected %b, got %b", $time, due.doc_end,
                        rsp_data.doc_end);
               errors++;
            end
         end
      end
   end

endmodule

// ----- filelist.f -----
sv/hte_pkg.sv
sv/hte_front.sv
sv/hte_queue.sv
sv/hte_back.sv
sv/html_text_extractor_core.sv
tb/tb_top.sv
